// ===== design/fbd_pkg.sv =====
// Shared constants and types for the fractional baud divider search.
package fbd_pkg;

  localparam int DIV_W = 45;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int SCALE_W = 13;
  localparam int DIVR_W = 17;
  localparam logic [DIVR_W-1:0] DIV_MAX = 17'd65536;
  localparam logic [31:0] CORE_CLOCK_RST = 32'd12000000;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } fbd_div_res_t;

endpackage

// ===== design/fbd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module fbd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fbd_pkg::DIV_W-1:0]  num,
  input  logic [fbd_pkg::DIV_W-1:0]  den,
  output fbd_pkg::fbd_div_res_t      res
);

  localparam int W = fbd_pkg::DIV_W;

  logic                           busy_r;
  logic                           done_r;
  logic [fbd_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [W-1:0]                   nq_r;
  logic [W-1:0]                   rem_r;
  logic [W-1:0]                   den_r;
  logic [W:0]                     shifted;
  logic [W+1:0]                   diff;

  always_comb begin
    shifted = {rem_r, nq_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        nq_r   <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= fbd_pkg::DIV_CNT_W'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[W+1]) begin
          rem_r <= diff[W-1:0];
          nq_r  <= {nq_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          nq_r  <= {nq_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == fbd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = nq_r;

endmodule

// ===== design/fractional_baud_divider_search.sv =====
// Top level: sequencer, shared multiplier and result register of the baud divider search.
//
//   channel | direction | signals                                   | transfer
//   --------+-----------+-------------------------------------------+----------------------
//   in      | input     | in_valid/in_ready, in_target_baud         | one search request
//   out     | output    | out_valid/out_ready, divider/mult/err/found | one result
//   cfg     | input     | cfg_valid/cfg_ready, cfg_core_clock       | core clock register
//
// Each multiplier is tried with two multiplies plus two 45-step divisions on one divider.
// An item tries up to FRACTION_STEPS multipliers, fewer when a zero error ends the search;
// a zero baud goes straight to the output register.
// in_ready is high only while the sequencer is idle. A finished result waits in the output
// register, and the next transaction may already be accepted meanwhile.
// Synchronous reset restores core_clock to 12 MHz and empties the output register.
module fractional_baud_divider_search #(
  parameter int FRACTION_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_target_baud,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_divider_value,
  output logic [7:0]  out_fraction_mult,
  output logic [31:0] out_baud_error,
  output logic        out_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_core_clock
);

  localparam int W = fbd_pkg::DIV_W;
  localparam logic [7:0] LAST_M = 8'(FRACTION_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_ST1, S_DV1, S_MUL2, S_ST2, S_DV2, S_EVAL, S_OUT
  } state_t;

  state_t                      state_r;
  logic [31:0]                 core_clock_r;
  logic [31:0]                 baud_r;
  logic [7:0]                  m_r;
  logic [W-1:0]                prod_r;
  logic [fbd_pkg::DIVR_W-1:0]  d_r;
  logic [fbd_pkg::DIVR_W-1:0]  d_nxt;
  logic [31:0]                 err_r;
  logic [31:0]                 err_nxt;
  logic                        have_r;
  logic [31:0]                 best_err_r;
  logic [15:0]                 best_div_r;
  logic [7:0]                  best_mult_r;
  logic                        out_valid_r;
  logic [15:0]                 out_div_r;
  logic [7:0]                  out_mult_r;
  logic [31:0]                 out_err_r;
  logic                        out_found_r;

  logic [fbd_pkg::SCALE_W-1:0] scale;
  logic [31:0]                 mul_b;
  logic [W-1:0]                mul_p;
  logic                        div_start;
  logic [W-1:0]                div_num;
  fbd_pkg::fbd_div_res_t       div_res;
  logic [31:0]                 actual;
  logic                        upd;

  // (256 + m) * 16
  assign scale = {1'b1, m_r, 4'b0000};
  assign mul_b = (state_r == S_MUL2) ? 32'(d_r) : baud_r;
  assign mul_p = W'(scale) * W'(mul_b);

  assign div_start = (state_r == S_ST1) || (state_r == S_ST2);
  assign div_num   = W'({core_clock_r, 8'h00}) + (prod_r >> 1);

  fbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (prod_r),
    .res   (div_res)
  );

  // achieved baud stays below 2^29
  assign actual = div_res.quo[31:0];

  always_comb begin
    if (div_res.quo == '0) begin
      d_nxt = fbd_pkg::DIVR_W'(1);
    end else if (div_res.quo > W'(fbd_pkg::DIV_MAX)) begin
      d_nxt = fbd_pkg::DIV_MAX;
    end else begin
      d_nxt = div_res.quo[fbd_pkg::DIVR_W-1:0];
    end
    err_nxt = (actual > baud_r) ? (actual - baud_r) : (baud_r - actual);
    upd     = !have_r || (err_r < best_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      core_clock_r <= fbd_pkg::CORE_CLOCK_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        core_clock_r <= cfg_core_clock;
      end
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            baud_r      <= in_target_baud;
            m_r         <= '0;
            have_r      <= 1'b0;
            best_err_r  <= '0;
            best_div_r  <= '0;
            best_mult_r <= '0;
            state_r     <= (in_target_baud == '0) ? S_OUT : S_MUL1;
          end
        end
        S_MUL1: begin
          prod_r  <= mul_p;
          state_r <= S_ST1;
        end
        S_ST1: state_r <= S_DV1;
        S_DV1: begin
          if (div_res.done) begin
            d_r     <= d_nxt;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod_r  <= mul_p;
          state_r <= S_ST2;
        end
        S_ST2: state_r <= S_DV2;
        S_DV2: begin
          if (div_res.done) begin
            err_r   <= err_nxt;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (upd) begin
            have_r      <= 1'b1;
            best_err_r  <= err_r;
            best_div_r  <= 16'(d_r - fbd_pkg::DIVR_W'(1));
            best_mult_r <= m_r;
          end
          if ((upd && (err_r == '0)) || (m_r == LAST_M)) begin
            state_r <= S_OUT;
          end else begin
            m_r     <= m_r + 8'd1;
            state_r <= S_MUL1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_div_r   <= best_div_r;
            out_mult_r  <= best_mult_r;
            out_err_r   <= best_err_r;
            out_found_r <= have_r;
            state_r     <= S_IDLE;
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_divider_value = out_div_r;
  assign out_fraction_mult = out_mult_r;
  assign out_baud_error    = out_err_r;
  assign out_found         = out_found_r;

endmodule

// ===== design/fbd_chk.sv =====
// Port-level checker for the baud divider search, bound to the top level.
module fbd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_divider_value,
  input logic [7:0]  out_fraction_mult,
  input logic [31:0] out_baud_error,
  input logic        out_found
);

  // a waiting result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divider_value)
      && $stable(out_fraction_mult) && $stable(out_baud_error) && $stable(out_found))
    else $error("result changed while stalled");

  // no candidate means an all-zero result
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_divider_value == 16'd0 && out_fraction_mult == 8'd0
      && out_baud_error == 32'd0)
    else $error("non-zero result without candidate");

  // one transaction at a time through the search
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while searching");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left result pending");

endmodule

bind fractional_baud_divider_search fbd_chk u_fbd_chk (.*);
